// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the scheduler RTL.
// No dependencies; simulation-only bodies, empty for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge out of reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- hdl/msts_pkg.sv -----
// Types and constants for the multi-slot task scheduler.
// No dependencies.
package msts_pkg;

   localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
   localparam int          REQ_DATA_W = 80;
   localparam int          RSP_DATA_W = 40;
   localparam int          FLAG_W     = 8;

   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_SCHED = 2'd1,
      REQ_STOP  = 2'd2,
      REQ_CLEAR = 2'd3
   } req_kind_type;

   typedef struct packed {
      req_kind_type kind;
      logic [2:0]   slot;
      logic [31:0]  period;
      logic         auto_reload;
      logic [31:0]  offset;
      logic [7:0]   clear_mask;
   } req_item_type;

endpackage

// ----- hdl/multi_slot_task_scheduler_core.sv -----
// Multi-slot task scheduler: tick time base, SLOTS timer slots, one result per request.
// A request is registered in the request stage on transfer; its result is registered in
// the response register when it is free. Throughput: one request per cycle while
// the output is not stalled; the per-slot compare and add sets the cycle.
// Reset (synchronous, active high) zeroes the time, all slots and both stage valids.
`include "assert_macros.svh"

module multi_slot_task_scheduler_core
   import msts_pkg::*;
#(
   parameter int SLOTS = 8
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tdata: slot[2:0], period[34:3], auto_reload[35], offset[67:36],
   //        clear_mask[75:68], zero pad[79:76]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: req_type[1:0]
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tdata: pending_flags[7:0], time_now[39:8]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic               item_valid;
   req_item_type       item;
   logic               advance;
   logic [31:0]        time_count_ff, time_count_in;
   logic [31:0]        time_inc;
   logic [31:0]        time_next;
   logic [31:0]        sched_sum;
   logic [SLOTS-1:0]   fired_next;
   logic [FLAG_W-1:0]  flags_next;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FLAG_W-1:0]  rsp_flags_ff;
   logic [31:0]        rsp_time_ff;

   assign advance = item_valid && (!rsp_valid_ff || rsp_tready);

   msts_req_stage u_req_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   // The time skips all-ones so an idle deadline never matches.
   assign time_inc  = time_count_ff + 32'd1;
   assign time_next = (time_inc == ALL_ONES) ? 32'd0 : time_inc;
   assign sched_sum = time_count_ff + item.period + item.offset;

   always_comb begin
      time_count_in = time_count_ff;
      if (item.kind == REQ_TICK) begin
         time_count_in = time_next;
      end
   end

   for (genvar i = 0; i < SLOTS; i++) begin : g_slot
      msts_slot #(
         .IDX (i)
      ) u_slot (
         .clock     (clock),
         .reset     (reset),
         .upd       (advance),
         .item      (item),
         .time_next (time_next),
         .sched_sum (sched_sum),
         .fired_in  (fired_next[i])
      );
   end

   for (genvar i = 0; i < FLAG_W; i++) begin : g_flag
      if (i < SLOTS) begin : g_present
         assign flags_next[i] = fired_next[i];
      end else begin : g_absent
         assign flags_next[i] = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_count_ff <= 32'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            time_count_ff <= time_count_in;
         end
      end
      if (advance) begin
         rsp_flags_ff <= flags_next;
         rsp_time_ff  <= time_count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_time_ff, rsp_flags_ff};

   `ASSERT_IMPLIES(a_time_never_idle, clock, reset, 1'b1, time_count_ff != ALL_ONES)
   `ASSERT_NEXT(a_tick_advances, clock, reset, advance && item.kind == REQ_TICK, time_count_ff == $past(time_next))
   `ASSERT_NEXT(a_result_loaded, clock, reset, advance, rsp_valid_ff && rsp_time_ff == time_count_ff)

endmodule

// ----- hdl/msts_req_stage.sv -----
// Input register of the scheduler: holds one request transfer and unpacks it.
// Depends on msts_pkg.
module msts_req_stage
   import msts_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tdata: slot[2:0], period[34:3], auto_reload[35], offset[67:36],
   //        clear_mask[75:68], zero pad[79:76]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: req_type[1:0]
   input  logic [1:0]            req_tuser,
   input  logic                  advance,
   output logic                  item_valid,
   output req_item_type          item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;

   assign req_tready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
      item_in             = item_ff;
      if (req_tvalid && req_tready) begin
         item_in.kind        = req_kind_type'(req_tuser);
         item_in.slot        = req_tdata[2:0];
         item_in.period      = req_tdata[34:3];
         item_in.auto_reload = req_tdata[35];
         item_in.offset      = req_tdata[67:36];
         item_in.clear_mask  = req_tdata[75:68];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ----- hdl/msts_slot.sv -----
// One timer slot: deadline, period, reload bit and pending flag with update logic.
// Depends on msts_pkg.
module msts_slot
   import msts_pkg::*;
#(
   parameter int unsigned IDX = 0
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         upd,
   input  req_item_type item,
   input  logic [31:0]  time_next,
   input  logic [31:0]  sched_sum,
   output logic         fired_in
);

   localparam logic [2:0] MASK_BIT = 3'(IDX % 8);
   localparam bit         HAS_MASK = (IDX < 8);

   logic [31:0] deadline_ff, deadline_in;
   logic [31:0] period_ff, period_in;
   logic        reload_ff, reload_in;
   logic        fired_ff;
   logic        sel;
   logic [31:0] reload_sum;

   // Period zero or all-ones leaves the slot idle; a sum landing on all-ones wraps to 0.
   function automatic logic [31:0] prog_deadline(input logic [31:0] sum,
                                                 input logic [31:0] per);
      logic [31:0] res;
      if (per == 32'd0 || per == ALL_ONES) begin
         res = ALL_ONES;
      end else if (sum == ALL_ONES) begin
         res = 32'd0;
      end else begin
         res = sum;
      end
      return res;
   endfunction

   assign sel        = (32'(item.slot) == IDX);
   assign reload_sum = time_next + period_ff;

   always_comb begin
      deadline_in = deadline_ff;
      period_in   = period_ff;
      reload_in   = reload_ff;
      fired_in    = fired_ff;
      case (item.kind)
         REQ_TICK: begin
            if (deadline_ff == time_next) begin
               fired_in = 1'b1;
               if (reload_ff) begin
                  deadline_in = prog_deadline(reload_sum, period_ff);
               end else begin
                  deadline_in = ALL_ONES;
               end
            end
         end
         REQ_SCHED: begin
            if (sel) begin
               deadline_in = prog_deadline(sched_sum, item.period);
               period_in   = item.period;
               reload_in   = item.auto_reload;
               if (item.period == 32'd0) begin
                  fired_in = 1'b1;
               end
            end
         end
         REQ_STOP: begin
            if (sel) begin
               deadline_in = ALL_ONES;
               period_in   = ALL_ONES;
               reload_in   = 1'b0;
            end
         end
         REQ_CLEAR: begin
            if (HAS_MASK && item.clear_mask[MASK_BIT]) begin
               fired_in = 1'b0;
            end
         end
         default: begin
            fired_in = fired_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deadline_ff <= 32'd0;
         period_ff   <= 32'd0;
         reload_ff   <= 1'b0;
         fired_ff    <= 1'b0;
      end else if (upd) begin
         deadline_ff <= deadline_in;
         period_ff   <= period_in;
         reload_ff   <= reload_in;
         fired_ff    <= fired_in;
      end
   end

endmodule
